/* design/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for the PID exclusion set
// Request and result beats, request codes, and the link passed cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

	localparam int PID_W = 13;

	// request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] pid_value;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] unique_count;
		logic       accepted;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic [PID_W-1:0] key;
		logic             ins;
		logic             clr;
	} cell_cmd_t;

	// what one cell hands to the next one down the row
	typedef struct packed {
		logic [PID_W-1:0] entry;
		logic             less;
		logic             valid;
	} link_t;

endpackage

`default_nettype wire

/* design/pes_cell.sv */
// ----------------------------------------------------------------------------
// pes_cell: one slot of the sorted set
// Holds one PID and its valid bit, compares it to the key, and on insert
// keeps, takes the key, or takes its upstream neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pes_pkg::cell_cmd_t cmd,
	input  wire pes_pkg::link_t   up,
	output pes_pkg::link_t        down,
	output logic                  eq
);
	import pes_pkg::*;

	logic [PID_W-1:0] entry_q;
	logic             valid_q;
	logic             less;

	// compare against the broadcast key
	assign less = valid_q && (entry_q < cmd.key);
	assign eq   = valid_q && (entry_q == cmd.key);

	assign down.entry = entry_q;
	assign down.less  = less;
	assign down.valid = valid_q;

	// valid bit: thermometer over the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !less) begin
			valid_q <= up.valid;
		end
	end

	// entry: insertion point takes the key, cells below shift down
	always_ff @(posedge clk) begin
		if (cmd.ins && !less) begin
			entry_q <= up.less ? cmd.key : up.entry;
		end
	end

endmodule

`default_nettype wire

/* design/pes_chain.sv */
// ----------------------------------------------------------------------------
// pes_chain: row of set cells
// Links the cells head to tail and gathers the match flags into one hit.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_chain #(
	parameter int N = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pes_pkg::cell_cmd_t cmd,
	output logic                    found
);
	import pes_pkg::*;

	link_t        link [N+1];
	logic [N-1:0] eq;

	// head of the row: always "valid and below the key" so cell 0 can take it
	assign link[0].entry = cmd.key;
	assign link[0].less  = 1'b1;
	assign link[0].valid = 1'b1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		pes_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.up     (link[i]),
			.down   (link[i+1]),
			.eq     (eq[i])
		);
	end

	assign found = |eq;

endmodule

`default_nettype wire

/* design/pid_exclusion_set_unit.sv */
// ----------------------------------------------------------------------------
// pid_exclusion_set_unit: sorted exclusion set of transport-stream PIDs
// Clear, add and lookup requests on a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload | handshake
//  req     | in  | req_t   | req_valid / req_stall
//  rsp     | out | rsp_t   | rsp_valid / rsp_stall
//
//  Each request runs in order: the beat is registered, then every cell
//  compares its entry to the key and the row inserts in the same cycle.
//  A new request is taken while the previous result waits in the output
//  register; a stalled result holds the compare stage until it drains.
//  Reset clears the valid bits and both counts at once; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_exclusion_set_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pes_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pes_pkg::rsp_t      rsp
);
	import pes_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

	req_t          req_s1;
	logic          valid_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] taken_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          commit;
	logic          in_range;
	logic          found;
	logic          add_ok;
	logic          do_ins;
	logic          do_clr;
	logic          hit;
	logic [CW-1:0] count_nx;
	logic [CW+6:0] count_ext;
	cell_cmd_t     cmd;

	assign req_stall = valid_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// compare stage retires when the output slot is free
	assign commit   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign in_range = (req_s1.pid_value[15:PID_W] == '0);

	// request decode
	always_comb begin
		add_ok = 1'b0;
		hit    = 1'b0;
		do_clr = 1'b0;
		case (req_s1.req_type)
			REQ_CLEAR:  do_clr = 1'b1;
			REQ_ADD:    add_ok = in_range && (taken_q < CAP);
			REQ_LOOKUP: hit    = in_range && found;
			default:    ;
		endcase
	end

	assign do_ins = commit && add_ok && !found && (count_q < CAP);

	assign cmd.key = req_s1.pid_value[PID_W-1:0];
	assign cmd.ins = do_ins;
	assign cmd.clr = commit && do_clr;

	pes_chain #(.N(MAX_ENTRIES)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.found  (found)
	);

	// count after this request
	always_comb begin
		if (do_clr) begin
			count_nx = '0;
		end else if (add_ok && !found && (count_q < CAP)) begin
			count_nx = count_q + CW'(1);
		end else begin
			count_nx = count_q;
		end
	end
	assign count_ext = {7'd0, count_nx};

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// set counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			taken_q <= '0;
		end else if (commit) begin
			count_q <= count_nx;
			if (do_clr) begin
				taken_q <= '0;
			end else if (add_ok) begin
				taken_q <= taken_q + CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.hit          <= hit;
			rsp_q.unique_count <= count_ext[6:0];
			rsp_q.accepted     <= add_ok;
		end
	end

endmodule

`default_nettype wire

/* design/pes_checker.sv */
// ----------------------------------------------------------------------------
// pes_checker: port-level checks for the PID exclusion set
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire pes_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire pes_pkg::rsp_t rsp
);
	import pes_pkg::*;

	// one request at a time in the compare stage
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while compare stage busy");

	// stalled request beat holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// a result never carries both a lookup hit and an accepted add
	a_hit_xor_acc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.accepted))
		else $error("hit and accepted both set");

	// a hit or an accepted add leaves a non-empty set
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.hit || rsp.accepted) |-> rsp.unique_count != 7'd0)
		else $error("empty set reported with hit or accepted");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind pid_exclusion_set_unit pes_checker u_pes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: regression for pid_exclusion_set_unit
// A queue-fed driver offers clear, add and lookup beats with random pauses.
// A presence-map model predicts each result. A monitor stalls at random and
// compares every result beat with the oldest prediction. One long receiver
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import pes_pkg::*;

	localparam int          SET_CAP     = 64;
	localparam logic [15:0] PID_MAX     = 16'd8191;
	localparam logic [1:0]  REQ_SPARE   = 2'd3;
	localparam int          RAND_ITEMS  = 400;
	localparam int          HOLD_CYCLES = 300;
	localparam int          HOLD_AFTER  = 60;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pid_exclusion_set_unit #(.MAX_ENTRIES(SET_CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// model state: which PIDs are held, distinct count, budget used
	logic [8191:0] pid_held;
	int unsigned   held_count;
	int unsigned   budget_used;

	req_t req_pending_q[$];
	rsp_t rsp_expect_q[$];
	int   fail_count = 0;
	int   rsp_seen   = 0;
	int   queued     = 0;
	int   n_total    = 0;

	// apply one request to the model set, return the result it should give
	function automatic rsp_t pid_set_apply(req_t r);
		rsp_t o;
		o = '0;
		case (r.req_type)
			REQ_CLEAR: begin
				pid_held    = '0;
				held_count  = 0;
				budget_used = 0;
			end
			REQ_ADD: begin
				if (r.pid_value <= PID_MAX && budget_used < SET_CAP) begin
					budget_used++;
					o.accepted = 1'b1;
					if (!pid_held[r.pid_value[PID_W-1:0]] && held_count < SET_CAP) begin
						pid_held[r.pid_value[PID_W-1:0]] = 1'b1;
						held_count++;
					end
				end
			end
			REQ_LOOKUP: begin
				if (r.pid_value <= PID_MAX)
					o.hit = pid_held[r.pid_value[PID_W-1:0]];
			end
			default: ;
		endcase
		o.unique_count = held_count[6:0];
		return o;
	endfunction

	// mostly back to back, some short pauses, a few long ones
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_req(logic [1:0] kind, logic [15:0] value);
		req_t r;
		r.req_type  = kind;
		r.pid_value = value;
		req_pending_q.push_back(r);
		queued++;
	endtask

	// clear (usually), a burst of adds from a small pool, then lookups
	task automatic fill_and_probe(bit force_full);
		logic [15:0] pool[$];
		int unsigned pool_n, n_add, n_look, i, r;
		bit          long_run;
		long_run = force_full || ($urandom_range(0, 3) == 0);
		if (force_full || $urandom_range(0, 9) < 6)
			queue_req(REQ_CLEAR, 16'($urandom_range(0, 65535)));
		pool_n = long_run ? $urandom_range(40, 80) : $urandom_range(1, 24);
		for (i = 0; i < pool_n; i++) begin
			if (!force_full && $urandom_range(0, 9) == 0)
				pool.push_back(16'($urandom_range(8192, 65535)));
			else
				pool.push_back(16'($urandom_range(0, 8191)));
		end
		n_add = force_full ? 72 : (long_run ? $urandom_range(60, 72) : $urandom_range(1, 20));
		for (i = 0; i < n_add; i++) begin
			queue_req(REQ_ADD, pool[$urandom_range(0, pool.size() - 1)]);
			if ($urandom_range(0, 4) == 0)
				queue_req(REQ_LOOKUP, pool[$urandom_range(0, pool.size() - 1)]);
		end
		n_look = $urandom_range(1, 12);
		for (i = 0; i < n_look; i++) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				queue_req(REQ_LOOKUP, pool[$urandom_range(0, pool.size() - 1)]);
			else if (r < 8)
				queue_req(REQ_LOOKUP, 16'($urandom_range(0, 8191)));
			else
				queue_req(REQ_LOOKUP, 16'($urandom_range(0, 65535)));
		end
	endtask

	// loose beats: any code, any value
	task automatic queue_noise();
		int unsigned n, i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			queue_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
	endtask

	// quiet windows in which no new pauses start on either side
	logic [15:0] cyc;
	logic        hold_on, hold_done;
	int          hold_left;
	wire         calm = (cyc[9:8] == 2'b11);

	// long receiver hold-off, counted here, so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc       <= '0;
			hold_on   <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else begin
			cyc <= cyc + 1'b1;
			if (hold_on) begin
				if (hold_left == 0)
					hold_on <= 1'b0;
				else
					hold_left <= hold_left - 1;
			end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
				hold_on   <= 1'b1;
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end
		end
	end

	// request driver
	int unsigned req_pause;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			req_pause <= 0;
		end else begin
			if (req_valid && !req_stall)
				rsp_expect_q.push_back(pid_set_apply(req));
			if (!req_valid || !req_stall) begin
				if (req_pause != 0) begin
					req_valid <= 1'b0;
					req_pause <= req_pause - 1;
				end else if (req_pending_q.size() != 0) begin
					req       <= req_pending_q.pop_front();
					req_valid <= 1'b1;
					req_pause <= calm ? 0 : pick_pause();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and random stall
	logic        jitter_stall = 1'b0;
	int unsigned jitter_left;
	rsp_t        rsp_want;
	assign rsp_stall = hold_on | jitter_stall;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_stall <= 1'b0;
			jitter_left  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen <= rsp_seen + 1;
				if (rsp_expect_q.size() == 0) begin
					$error("result beat with nothing expected: hit %0d unique_count %0d accepted %0d",
						rsp.hit, rsp.unique_count, rsp.accepted);
					fail_count++;
				end else begin
					rsp_want = rsp_expect_q.pop_front();
					if (rsp.hit !== rsp_want.hit) begin
						$error("hit expected %0d got %0d", rsp_want.hit, rsp.hit);
						fail_count++;
					end
					if (rsp.unique_count !== rsp_want.unique_count) begin
						$error("unique_count expected %0d got %0d",
							rsp_want.unique_count, rsp.unique_count);
						fail_count++;
					end
					if (rsp.accepted !== rsp_want.accepted) begin
						$error("accepted expected %0d got %0d", rsp_want.accepted, rsp.accepted);
						fail_count++;
					end
				end
			end
			if (jitter_left != 0) begin
				jitter_left  <= jitter_left - 1;
				jitter_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				jitter_stall <= 1'b1;
				jitter_left  <= pick_pause();
			end else begin
				jitter_stall <= 1'b0;
			end
		end
	end

	// stimulus and end of run
	initial begin
		pid_held    = '0;
		held_count  = 0;
		budget_used = 0;

		// directed: empty set, range edges, duplicates, spare code, clear
		queue_req(REQ_CLEAR, 16'h0000);
		queue_req(REQ_LOOKUP, 16'h0000);
		queue_req(REQ_ADD, 16'h0000);
		queue_req(REQ_ADD, PID_MAX);
		queue_req(REQ_ADD, PID_MAX + 16'd1);
		queue_req(REQ_ADD, 16'hFFFF);
		queue_req(REQ_ADD, 16'h0000);
		queue_req(REQ_ADD, 16'd100);
		queue_req(REQ_LOOKUP, 16'h0000);
		queue_req(REQ_LOOKUP, PID_MAX);
		queue_req(REQ_LOOKUP, PID_MAX + 16'd1);
		queue_req(REQ_LOOKUP, 16'hFFFF);
		queue_req(REQ_LOOKUP, 16'd100);
		queue_req(REQ_LOOKUP, 16'd101);
		queue_req(REQ_SPARE, 16'hFFFF);
		queue_req(REQ_SPARE, 16'h0000);
		queue_req(REQ_ADD, 16'd5000);
		queue_req(REQ_LOOKUP, 16'd5000);
		queue_req(REQ_ADD, 16'h2000 | 16'd5000);
		queue_req(REQ_CLEAR, 16'hFFFF);
		queue_req(REQ_LOOKUP, 16'h0000);
		queue_req(REQ_LOOKUP, 16'd5000);

		// random: first burst runs the budget dry, the rest mostly bursts
		queued = 0;
		fill_and_probe(1'b1);
		while (queued < RAND_ITEMS) begin
			if ($urandom_range(0, 9) < 8)
				fill_and_probe(1'b0);
			else
				queue_noise();
		end
		n_total = req_pending_q.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// every queued beat must come back as a checked result
		while (rsp_seen < n_total)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
design/pes_pkg.sv
design/pes_cell.sv
design/pes_chain.sv
design/pid_exclusion_set_unit.sv
design/pes_checker.sv
sim/testbench.sv
